// File: rtl/core/tpe_pkg.sv
// shared types, codes and reset values of the tape pulse encoder
package tpe_pkg;

   // item kinds carried in the request tuser
   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_BYTE  = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // block phases
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PILOT = 3'd1,
      PH_SYNC1 = 3'd2,
      PH_SYNC2 = 3'd3,
      PH_DATA  = 3'd4,
      PH_PAUSE = 3'd5
   } phase_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PILOT_PULSES = 3'd0,
      CSR_PILOT_LEN    = 3'd1,
      CSR_SYNC1_LEN    = 3'd2,
      CSR_SYNC2_LEN    = 3'd3,
      CSR_ZERO_LEN     = 3'd4,
      CSR_ONE_LEN      = 3'd5,
      CSR_PAUSE_LEN    = 3'd6,
      CSR_UNUSED       = 3'd7
   } csr_index_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COUNT_W    = 16;
   localparam int LEN_W      = 12;

   localparam logic [COUNT_W-1:0] RST_PILOT_PULSES = 16'd8064;
   localparam logic [LEN_W-1:0]   RST_PILOT_LEN    = 12'd28;
   localparam logic [LEN_W-1:0]   RST_SYNC1_LEN    = 12'd9;
   localparam logic [LEN_W-1:0]   RST_SYNC2_LEN    = 12'd10;
   localparam logic [LEN_W-1:0]   RST_ZERO_LEN     = 12'd11;
   localparam logic [LEN_W-1:0]   RST_ONE_LEN      = 12'd22;
   localparam logic [COUNT_W-1:0] RST_PAUSE_LEN    = 16'd44100;

   // configuration bundle from the register file to the engine
   typedef struct packed {
      logic [COUNT_W-1:0] pilot_pulses;
      logic [LEN_W-1:0]   pilot_len;
      logic [LEN_W-1:0]   sync_first_len;
      logic [LEN_W-1:0]   sync_second_len;
      logic [LEN_W-1:0]   zero_len;
      logic [LEN_W-1:0]   one_len;
      logic [COUNT_W-1:0] pause_len;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic      sample_valid;
      logic      level;
      logic      byte_request;
      logic      underrun;
      phase_type phase;
      logic      block_end;
   } result_type;

endpackage

// File: rtl/core/tape_pulse_encoder.sv
// top level of the tape pulse encoder: register file, engine and result register
// Turns one tape block into a one-bit sample stream: a start word opens the block
// at level 0, then come the pilot tone, two sync pulses, the data bytes msb first
// (two short pulses for a zero bit, two long for a one) and a closing pause pulse,
// the level toggling at each pulse end. Every request word gives exactly one
// response word in the cycle after it is taken; sample words are tick requests.
// Throughput is one word per clock: the whole update is a counter increment, one
// compare against the pulse length and the phase step, between the block state
// and the response register, which lets a new word in whenever it is empty or
// being drained in the same cycle. Pulse lengths are sample counts; the user must
// write registers only while the block is quiet, which the block does not enforce.
module tape_pulse_encoder (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic [1:0]                     req_tuser,   // [1:0] mode
   input  logic                           req_tlast,   // last_byte
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [0] level, [1] byte_request,
                                                       // [2] underrun, [5:3] phase,
                                                       // [7:6] zero
   output logic                           rsp_tuser,   // sample_valid
   output logic                           rsp_tlast,   // block_end
   // configuration writes
   input  logic                           csr_we,
   input  logic [tpe_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tpe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpe_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   // take a word whenever the response slot is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   tpe_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpe_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_tuser),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .cfg       (cfg),
      .result    (result)
   );

   // response register, valid flag cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.phase, rsp_ff.underrun, rsp_ff.byte_request,
                        rsp_ff.level};
   assign rsp_tuser  = rsp_ff.sample_valid;
   assign rsp_tlast  = rsp_ff.block_end;

   // underrun only on a data-phase sample
   a_underrun_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.underrun |-> rsp_ff.sample_valid && rsp_ff.phase == PH_DATA)
      else $error("underrun outside a data-phase sample");

   // the block ends only on a pause sample
   a_end_in_pause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.block_end |-> rsp_ff.sample_valid && rsp_ff.phase == PH_PAUSE)
      else $error("block end outside the pause phase");

   // a start word always answers in the pilot phase at level zero
   a_start_pilot: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == MODE_START |=> rsp_ff.phase == PH_PILOT && !rsp_ff.level)
      else $error("start word did not open the pilot phase");

   // a stalled response keeps the slot closed to new words
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while response slot is full");

endmodule

// File: rtl/core/tpe_cfg.sv
// configuration register file of the tape pulse encoder
module tpe_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tpe_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tpe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tpe_pkg::cfg_type                 cfg
);
   import tpe_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pilot_pulses    <= RST_PILOT_PULSES;
         cfg_ff.pilot_len       <= RST_PILOT_LEN;
         cfg_ff.sync_first_len  <= RST_SYNC1_LEN;
         cfg_ff.sync_second_len <= RST_SYNC2_LEN;
         cfg_ff.zero_len        <= RST_ZERO_LEN;
         cfg_ff.one_len         <= RST_ONE_LEN;
         cfg_ff.pause_len       <= RST_PAUSE_LEN;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_PILOT_PULSES: cfg_ff.pilot_pulses    <= csr_wdata;
            CSR_PILOT_LEN:    cfg_ff.pilot_len       <= csr_wdata[LEN_W-1:0];
            CSR_SYNC1_LEN:    cfg_ff.sync_first_len  <= csr_wdata[LEN_W-1:0];
            CSR_SYNC2_LEN:    cfg_ff.sync_second_len <= csr_wdata[LEN_W-1:0];
            CSR_ZERO_LEN:     cfg_ff.zero_len        <= csr_wdata[LEN_W-1:0];
            CSR_ONE_LEN:      cfg_ff.one_len         <= csr_wdata[LEN_W-1:0];
            CSR_PAUSE_LEN:    cfg_ff.pause_len       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/tpe_engine.sv
// block state and per-word next-state and result logic
module tpe_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           mode,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  tpe_pkg::cfg_type     cfg,
   output tpe_pkg::result_type  result
);
   import tpe_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] pulse_ff, pulse_in;
   logic [COUNT_W-1:0] sample_ff, sample_in;
   logic               level_ff, level_in;
   logic [7:0]         shift_ff, shift_in;
   logic [2:0]         bit_ff, bit_in;
   logic               half_ff, half_in;
   logic               held_ff, held_in;
   logic               final_ff, final_in;

   logic [COUNT_W-1:0] sample_inc;
   logic [COUNT_W:0]   pulse_inc;
   logic [COUNT_W-1:0] pulse_len;
   logic               cur_bit;
   logic               in_block_old;
   logic               in_block_new;

   assign cur_bit      = shift_ff[3'd7 - bit_ff];
   assign sample_inc   = sample_ff + 16'd1;
   assign pulse_inc    = {1'b0, pulse_ff} + 17'd1;
   assign in_block_old = (phase_ff >= PH_PILOT) && (phase_ff <= PH_DATA);
   assign in_block_new = (phase_in >= PH_PILOT) && (phase_in <= PH_DATA);

   // length of the pulse in progress; zero acts as one sample by the >= compare
   always_comb begin
      case (phase_ff)
         PH_PILOT: pulse_len = {4'd0, cfg.pilot_len};
         PH_SYNC1: pulse_len = {4'd0, cfg.sync_first_len};
         PH_SYNC2: pulse_len = {4'd0, cfg.sync_second_len};
         PH_DATA:  pulse_len = cur_bit ? {4'd0, cfg.one_len} : {4'd0, cfg.zero_len};
         PH_PAUSE: pulse_len = cfg.pause_len;
         default:  pulse_len = 16'd1;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      pulse_in  = pulse_ff;
      sample_in = sample_ff;
      level_in  = level_ff;
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      half_in   = half_ff;
      held_in   = held_ff;
      final_in  = final_ff;

      result.sample_valid = 1'b0;
      result.level        = level_ff;
      result.underrun     = 1'b0;
      result.phase        = phase_ff;
      result.block_end    = 1'b0;

      case (mode_type'(mode))
         MODE_START: begin
            phase_in     = PH_PILOT;
            pulse_in     = '0;
            sample_in    = '0;
            level_in     = 1'b0;
            shift_in     = '0;
            bit_in       = '0;
            half_in      = 1'b0;
            held_in      = 1'b0;
            final_in     = 1'b0;
            result.level = 1'b0;
            result.phase = PH_PILOT;
         end
         MODE_BYTE: begin
            if (in_block_old && !held_ff) begin
               shift_in = data_byte;
               final_in = last_byte;
               bit_in   = '0;
               half_in  = 1'b0;
               held_in  = 1'b1;
            end
         end
         MODE_TICK: begin
            if ((phase_ff >= PH_PILOT) && (phase_ff <= PH_PAUSE)) begin
               result.sample_valid = 1'b1;
               if ((phase_ff == PH_DATA) && !held_ff) begin
                  result.underrun = 1'b1;
               end else begin
                  sample_in = sample_inc;
                  if (sample_inc >= pulse_len) begin
                     // pulse ends: toggle and move on
                     sample_in = '0;
                     level_in  = ~level_ff;
                     case (phase_ff)
                        PH_PILOT: begin
                           if (pulse_inc >= {1'b0, cfg.pilot_pulses}) begin
                              pulse_in = '0;
                              phase_in = PH_SYNC1;
                           end else begin
                              pulse_in = pulse_inc[COUNT_W-1:0];
                           end
                        end
                        PH_SYNC1: phase_in = PH_SYNC2;
                        PH_SYNC2: phase_in = PH_DATA;
                        PH_DATA: begin
                           if (!half_ff) begin
                              half_in = 1'b1;
                           end else begin
                              half_in = 1'b0;
                              if (bit_ff == 3'd7) begin
                                 bit_in  = '0;
                                 held_in = 1'b0;
                                 if (final_ff) begin
                                    phase_in = PH_PAUSE;
                                 end
                              end else begin
                                 bit_in = bit_ff + 3'd1;
                              end
                           end
                        end
                        PH_PAUSE: begin
                           phase_in         = PH_IDLE;
                           result.block_end = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         default: ;
      endcase

      result.byte_request = in_block_new && !held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pulse_ff  <= '0;
         sample_ff <= '0;
         level_ff  <= 1'b0;
         shift_ff  <= '0;
         bit_ff    <= '0;
         half_ff   <= 1'b0;
         held_ff   <= 1'b0;
         final_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pulse_ff  <= pulse_in;
         sample_ff <= sample_in;
         level_ff  <= level_in;
         shift_ff  <= shift_in;
         bit_ff    <= bit_in;
         half_ff   <= half_in;
         held_ff   <= held_in;
         final_ff  <= final_in;
      end
   end

endmodule

// File: bench/tb_tape_pulse_encoder.sv
// self-checking stream testbench for the tape pulse encoder
`timescale 1ns / 1ps

module tb_tape_pulse_encoder;
   import tpe_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 9;
   // generous ceiling, far above the slowest legal run with all the stalling
   localparam int RUN_LIMIT_NS = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request stream, driven from the start of the run
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0] req_tuser = MODE_NONE; // [1:0] mode
   logic       req_tlast = 1'b0;    // last_byte

   // response stream
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] level, [1] byte_request, [2] underrun,
                                    // [5:3] phase, [7:6] zero
   logic       rsp_tuser;           // sample_valid
   logic       rsp_tlast;           // block_end

   // register writes
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tape_pulse_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------
   // encoder mirror: register copy and block state
   // ------------------------------------------------------------------
   cfg_type cfg = '{RST_PILOT_PULSES, RST_PILOT_LEN, RST_SYNC1_LEN, RST_SYNC2_LEN,
                    RST_ZERO_LEN, RST_ONE_LEN, RST_PAUSE_LEN};

   phase_type   tape_phase = PH_IDLE;
   logic [15:0] tape_pulses = '0;     // pilot pulses done
   logic [15:0] tape_samples = '0;    // samples into the current pulse
   logic        tape_level = 1'b0;
   logic [7:0]  tape_shift = '0;
   logic [2:0]  tape_bit = '0;        // 0 is the msb
   logic        tape_half = 1'b0;     // second pulse of the bit
   logic        tape_loaded = 1'b0;   // a byte is held
   logic        tape_final = 1'b0;    // the held byte closes the block

   // responses still owed by the block, oldest first
   result_type awaited_words[$];

   int gap_pct = 0;     // sender idle chance per cycle, in percent
   int stall_pct = 0;   // receiver stall chance per cycle, in percent
   int fault_count = 0;

   // run statistics for the closing summary
   int words_sent = 0;
   int samples_seen = 0;
   int underruns_seen = 0;
   int blocks_closed = 0;
   int reg_writes = 0;

   // stream generator bookkeeping, one block at a time
   int block_bytes = 1;
   int bytes_given = 0;

   // directed plan: either a register write or a run of identical words
   typedef struct {
      logic          is_reg;
      csr_index_type idx;
      logic [15:0]   val;
      mode_type      mode;
      logic [7:0]    data;
      logic          last;
      int            reps;
      logic          typed;
      result_type    known;
   } plan_row_type;

   localparam plan_row_type EMPTY_ROW = '{1'b0, CSR_UNUSED, 16'h0000, MODE_NONE, 8'h00,
                                          1'b0, 0, 1'b0, '0};

   plan_row_type plan[$];

   // next response of the encoder for one accepted word; advances the mirror
   function automatic result_type encode_word(mode_type m, logic [7:0] d, logic l);
      result_type  r;
      logic [15:0] plen;
      r = '0;
      r.level = tape_level;
      r.phase = tape_phase;
      case (m)
         MODE_START: begin
            // a start always reopens the block, even mid-block
            tape_phase = PH_PILOT;
            tape_pulses = '0;
            tape_samples = '0;
            tape_level = 1'b0;
            tape_shift = '0;
            tape_bit = '0;
            tape_half = 1'b0;
            tape_loaded = 1'b0;
            tape_final = 1'b0;
            r.level = 1'b0;
            r.phase = PH_PILOT;
         end
         MODE_BYTE: begin
            // taken early in pilot and sync too, dropped in idle, pause or when full
            if (tape_phase >= PH_PILOT && tape_phase <= PH_DATA && !tape_loaded) begin
               tape_shift = d;
               tape_final = l;
               tape_bit = '0;
               tape_half = 1'b0;
               tape_loaded = 1'b1;
            end
         end
         MODE_TICK: begin
            if (tape_phase != PH_IDLE) begin
               r.sample_valid = 1'b1;
               if (tape_phase == PH_DATA && !tape_loaded) begin
                  // starved: hold the level, no counter moves
                  r.underrun = 1'b1;
               end else begin
                  case (tape_phase)
                     PH_PILOT: plen = 16'(cfg.pilot_len);
                     PH_SYNC1: plen = 16'(cfg.sync_first_len);
                     PH_SYNC2: plen = 16'(cfg.sync_second_len);
                     PH_DATA:  plen = tape_shift[3'd7 - tape_bit] ? 16'(cfg.one_len)
                                                                  : 16'(cfg.zero_len);
                     default:  plen = cfg.pause_len;
                  endcase
                  tape_samples = tape_samples + 16'd1;
                  // a zero length still lasts one sample
                  if (tape_samples >= plen) begin
                     tape_samples = '0;
                     tape_level = ~tape_level;
                     case (tape_phase)
                        PH_PILOT: begin
                           // a pilot count of zero behaves as one pulse
                           if ({1'b0, tape_pulses} + 17'd1 >= {1'b0, cfg.pilot_pulses}) begin
                              tape_pulses = '0;
                              tape_phase = PH_SYNC1;
                           end else begin
                              tape_pulses = tape_pulses + 16'd1;
                           end
                        end
                        PH_SYNC1: tape_phase = PH_SYNC2;
                        PH_SYNC2: tape_phase = PH_DATA;
                        PH_DATA: begin
                           if (!tape_half) begin
                              tape_half = 1'b1;
                           end else begin
                              tape_half = 1'b0;
                              if (tape_bit == 3'd7) begin
                                 tape_bit = '0;
                                 tape_loaded = 1'b0;
                                 if (tape_final) tape_phase = PH_PAUSE;
                              end else begin
                                 tape_bit = tape_bit + 3'd1;
                              end
                           end
                        end
                        default: begin
                           tape_phase = PH_IDLE;
                           r.block_end = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
         default: ;
      endcase
      r.byte_request = tape_phase >= PH_PILOT && tape_phase <= PH_DATA && !tape_loaded;
      return r;
   endfunction

   function automatic void check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fault_count++;
      end
   endfunction

   function automatic void add_word(mode_type m, logic [7:0] d, logic l, int reps);
      plan_row_type row;
      row = EMPTY_ROW;
      row.mode = m;
      row.data = d;
      row.last = l;
      row.reps = reps;
      plan.push_back(row);
   endfunction

   function automatic void add_known(mode_type m, logic [7:0] d, logic l, result_type k);
      plan_row_type row;
      row = EMPTY_ROW;
      row.mode = m;
      row.data = d;
      row.last = l;
      row.reps = 1;
      row.typed = 1'b1;
      row.known = k;
      plan.push_back(row);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [15:0] v);
      plan_row_type row;
      row = EMPTY_ROW;
      row.is_reg = 1'b1;
      row.idx = idx;
      row.val = v;
      plan.push_back(row);
   endfunction

   // offer one word, wait for the handshake, then queue its expected response
   task automatic send_word(mode_type m, logic [7:0] d, logic l, logic typed,
                            result_type known);
      result_type r;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= d;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = encode_word(m, d, l);
      awaited_words.push_back(typed ? known : r);
      words_sent++;
      if (r.sample_valid) samples_seen++;
      if (r.underrun) underruns_seen++;
      if (r.block_end) blocks_closed++;
   endtask

   // registers change only once every owed response has come back
   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_PILOT_PULSES: cfg.pilot_pulses = v;
         CSR_PILOT_LEN:    cfg.pilot_len = v[LEN_W-1:0];
         CSR_SYNC1_LEN:    cfg.sync_first_len = v[LEN_W-1:0];
         CSR_SYNC2_LEN:    cfg.sync_second_len = v[LEN_W-1:0];
         CSR_ZERO_LEN:     cfg.zero_len = v[LEN_W-1:0];
         CSR_ONE_LEN:      cfg.one_len = v[LEN_W-1:0];
         CSR_PAUSE_LEN:    cfg.pause_len = v;
         default: ;
      endcase
      reg_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed blocks: start, ticks, bytes fed on request with the last
   // one flagged; some starving, restarts, stray bytes and unknown words mixed in
   task automatic drive_traffic(int n);
      int         done;
      int         r;
      logic       wanted;
      mode_type   m;
      logic [7:0] d;
      logic       l;
      done = 0;
      while (done < n) begin
         wanted = tape_phase >= PH_PILOT && tape_phase <= PH_DATA && !tape_loaded;
         d = 8'($urandom);
         l = 1'($urandom);
         r = $urandom_range(999);
         if (tape_phase == PH_IDLE) begin
            m = (r < 800) ? MODE_START : (r < 880) ? MODE_TICK
              : (r < 940) ? MODE_BYTE : MODE_NONE;
         end else if (wanted && r < ((tape_phase == PH_DATA) ? 750 : 300)) begin
            m = MODE_BYTE;
         end else begin
            m = (r < 920) ? MODE_TICK : (r < 960) ? MODE_BYTE
              : (r < 990) ? MODE_NONE : MODE_START;
         end
         if (m == MODE_BYTE && wanted) begin
            bytes_given++;
            // now and then a block is cut short by an early last byte
            l = bytes_given >= block_bytes || $urandom_range(49) == 0;
         end
         if (m == MODE_START) begin
            block_bytes = $urandom_range(1, 3);
            bytes_given = 0;
         end
         if (m == MODE_TICK || m == MODE_START || (m == MODE_BYTE && wanted)) done++;
         send_word(m, d, l, 1'b0, '0);
      end
   endtask

   // response side: random stalls and in-order checking of every word taken
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: response word with none expected, expected nothing, actual %h",
                     $time, {rsp_tlast, rsp_tuser, rsp_tdata});
            fault_count++;
         end else begin
            want = awaited_words.pop_front();
            check_field("sample_valid", want.sample_valid, rsp_tuser);
            check_field("level", want.level, rsp_tdata[0]);
            check_field("byte_request", want.byte_request, rsp_tdata[1]);
            check_field("underrun", want.underrun, rsp_tdata[2]);
            check_field("phase", int'(want.phase), rsp_tdata[5:3]);
            check_field("block_end", want.block_end, rsp_tlast);
            check_field("tdata padding", 0, rsp_tdata[7:6]);
         end
      end
      rsp_tready <= $urandom_range(99) >= stall_pct;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: timeout with %0d responses outstanding", $time, awaited_words.size());
      $display("tb_tape_pulse_encoder: errors");
      $finish;
   end

   initial begin
      logic [15:0] setting [7];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset values first: quiet words, early byte, restart
      add_known(MODE_TICK, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0});
      add_known(MODE_NONE, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0});
      add_known(MODE_BYTE, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0});
      add_known(MODE_START, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b0, PH_PILOT, 1'b0});
      add_known(MODE_BYTE, 8'hA5, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, PH_PILOT, 1'b0});
      add_word(MODE_BYTE, 8'h5A, 1'b1, 1);   // second byte while one is held
      add_known(MODE_TICK, 8'h00, 1'b0, '{1'b1, 1'b0, 1'b0, 1'b0, PH_PILOT, 1'b0});
      // restart drops the held byte, so a byte is requested again
      add_known(MODE_START, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b0, PH_PILOT, 1'b0});
      // zero count and lengths: one-sample pulses, two for a one; upper bits masked
      add_reg(CSR_PILOT_PULSES, 16'h0000);
      add_reg(CSR_PILOT_LEN, 16'h0000);
      add_reg(CSR_SYNC1_LEN, 16'h0000);
      add_reg(CSR_SYNC2_LEN, 16'hF000);
      add_reg(CSR_ZERO_LEN, 16'h0000);
      add_reg(CSR_ONE_LEN, 16'h0002);
      add_reg(CSR_PAUSE_LEN, 16'h0000);
      add_reg(CSR_UNUSED, 16'hFFFF);
      add_word(MODE_START, 8'h00, 1'b0, 1);
      add_word(MODE_TICK, 8'h00, 1'b0, 3);   // pilot, sync one, sync two
      // data phase with nothing held: sample at level 1, underrun flagged
      add_known(MODE_TICK, 8'h00, 1'b0, '{1'b1, 1'b1, 1'b1, 1'b1, PH_DATA, 1'b0});
      add_word(MODE_BYTE, 8'hFF, 1'b0, 1);
      add_word(MODE_TICK, 8'hFF, 1'b1, 2);
      add_known(MODE_START, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b0, PH_PILOT, 1'b0});

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            repeat (plan[i].reps)
               send_word(plan[i].mode, plan[i].data, plan[i].last, plan[i].typed,
                         plan[i].known);
         end
      end

      // random part: all-ones extremes, all zero, all one, then short random
      // settings; idling pattern rotates so every pattern sees two settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: foreach (setting[i]) setting[i] = 16'hFFFF;
            1: foreach (setting[i]) setting[i] = 16'h0000;
            2: foreach (setting[i]) setting[i] = 16'h0001;
            default: begin
               setting[CSR_PILOT_PULSES] = 16'($urandom_range(0, 6));
               for (int i = 1; i < 6; i++)
                  setting[i] = {4'($urandom), 12'($urandom_range(0, 5))};
               setting[CSR_PAUSE_LEN] = 16'($urandom_range(0, 12));
            end
         endcase
         for (int i = 0; i < 7; i++) write_reg(csr_index_type'(i), setting[i]);
         write_reg(CSR_UNUSED, 16'($urandom));
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase
         // the all-ones setting only gets into the pilot tone, so keep it short
         drive_traffic((p == 0) ? 60 : 250);
      end

      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("run covered %0d words and %0d register writes over 8 settings",
               words_sent, reg_writes);
      $display("  %0d samples, %0d underruns, %0d blocks closed by their pause",
               samples_seen, underruns_seen, blocks_closed);
      if (fault_count == 0) begin
         $display("tb_tape_pulse_encoder: clean");
      end else begin
         $display("tb_tape_pulse_encoder: errors");
      end
      $finish;
   end

endmodule
